// ===== sv/ble_adp_pkg.sv =====
package ble_adp_pkg;

  // Value bytes kept per structure
  localparam int unsigned CAPTURE_BYTES = 16;
  localparam int unsigned CNT_W         = $clog2(CAPTURE_BYTES + 1);

  // AD type codes
  localparam logic [7:0] TYPE_FLAGS        = 8'h01;
  localparam logic [7:0] TYPE_UUID16_PART  = 8'h02;
  localparam logic [7:0] TYPE_UUID16_FULL  = 8'h03;
  localparam logic [7:0] TYPE_UUID128_PART = 8'h06;
  localparam logic [7:0] TYPE_UUID128_FULL = 8'h07;
  localparam logic [7:0] TYPE_NAME_SHORT   = 8'h08;
  localparam logic [7:0] TYPE_NAME_FULL    = 8'h09;
  localparam logic [7:0] TYPE_TX_POWER     = 8'h0A;
  localparam logic [7:0] TYPE_COMPANY_ID   = 8'hFF;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_FLAGS    = 3'd1,
    KIND_TX_POWER = 3'd2,
    KIND_UUID16   = 3'd3,
    KIND_UUID128  = 3'd4,
    KIND_COMPANY  = 3'd5,
    KIND_NAME     = 3'd6
  } kind_e;

  // One result item
  typedef struct packed {
    logic        field_valid;
    logic [7:0]  field_type;
    logic [7:0]  val_len;
    kind_e       value_kind;
    logic [15:0] short_value;
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
    logic        end_of_payload;
  } result_t;

endpackage

// ===== sv/ble_adp_core.sv =====
module ble_adp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  input  logic                 res_free_i,
  output logic                 res_load_o,
  output ble_adp_pkg::result_t res_o
);
  import ble_adp_pkg::*;

  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_TYPE  = 2'd1,
    PH_VALUE = 2'd2,
    PH_SKIP  = 2'd3
  } phase_e;

  logic             in_vld_q;
  logic [7:0]       byte_q;
  logic             last_q;

  phase_e           phase_q, phase_d;
  logic [7:0]       length_q, length_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       vlen_q, vlen_d;
  logic [7:0]       left_q, left_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [63:0]      cap_lo_q, cap_lo_d;
  logic [63:0]      cap_hi_q, cap_hi_d;

  logic             done;
  logic             has_result;
  logic             advance;
  kind_e            kind;
  logic [15:0]      short_val;

  // Move the held byte on when it makes no result or the result register is free
  assign has_result = done || last_q;
  assign advance    = in_vld_q && (!has_result || res_free_i);
  assign in_ready_o = !in_vld_q || advance;
  assign res_load_o = in_vld_q && has_result && res_free_i;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  // Structure parser state update
  always_comb begin
    phase_d  = phase_q;
    length_d = length_q;
    type_d   = type_q;
    vlen_d   = vlen_q;
    left_d   = left_q;
    count_d  = count_q;
    cap_lo_d = cap_lo_q;
    cap_hi_d = cap_hi_q;
    done     = 1'b0;
    case (phase_q)
      PH_LEN: begin
        if (byte_q == 8'd0) begin
          phase_d = PH_SKIP;
        end else begin
          length_d = byte_q;
          type_d   = 8'd0;
          count_d  = '0;
          cap_lo_d = '0;
          cap_hi_d = '0;
          phase_d  = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_d = byte_q;
        vlen_d = length_q - 8'd1;
        left_d = length_q - 8'd1;
        if (length_q == 8'd1) begin
          done    = 1'b1;
          phase_d = PH_LEN;
        end else begin
          phase_d = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (count_q < CNT_W'(CAPTURE_BYTES)) begin
          if (!count_q[3]) begin
            cap_lo_d[{count_q[2:0], 3'b000} +: 8] = byte_q;
          end else begin
            cap_hi_d[{count_q[2:0], 3'b000} +: 8] = byte_q;
          end
          count_d = count_q + CNT_W'(1);
        end
        left_d = left_q - 8'd1;
        if (left_q == 8'd1) begin
          done    = 1'b1;
          phase_d = PH_LEN;
        end
      end
      default: begin
        phase_d = PH_SKIP;
      end
    endcase
    // Drop any open structure at the payload end
    if (last_q) begin
      phase_d = PH_LEN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN;
      length_q <= '0;
      type_q   <= '0;
      vlen_q   <= '0;
      left_q   <= '0;
      count_q  <= '0;
      cap_lo_q <= '0;
      cap_hi_q <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      type_q   <= type_d;
      vlen_q   <= vlen_d;
      left_q   <= left_d;
      count_q  <= count_d;
      cap_lo_q <= cap_lo_d;
      cap_hi_q <= cap_hi_d;
    end
  end

  // Classify the completed structure
  always_comb begin
    kind      = KIND_NONE;
    short_val = 16'd0;
    if (type_d == TYPE_FLAGS && vlen_d >= 8'd1) begin
      kind      = KIND_FLAGS;
      short_val = {8'd0, cap_lo_d[7:0]};
    end else if (type_d == TYPE_TX_POWER && vlen_d >= 8'd1) begin
      kind      = KIND_TX_POWER;
      short_val = {8'd0, cap_lo_d[7:0]};
    end else if ((type_d == TYPE_UUID16_PART || type_d == TYPE_UUID16_FULL)
                 && vlen_d >= 8'd2) begin
      kind      = KIND_UUID16;
      short_val = cap_lo_d[15:0];
    end else if ((type_d == TYPE_UUID128_PART || type_d == TYPE_UUID128_FULL)
                 && vlen_d >= 8'(CAPTURE_BYTES)) begin
      kind = KIND_UUID128;
    end else if (type_d == TYPE_COMPANY_ID && vlen_d >= 8'd2) begin
      kind      = KIND_COMPANY;
      short_val = cap_lo_d[15:0];
    end else if (type_d == TYPE_NAME_SHORT || type_d == TYPE_NAME_FULL) begin
      kind = KIND_NAME;
    end
  end

  // Build the result; zero all structure fields when none completed
  always_comb begin
    res_o                = '0;
    res_o.end_of_payload = last_q;
    if (done) begin
      res_o.field_valid  = 1'b1;
      res_o.field_type   = type_d;
      res_o.val_len      = vlen_d;
      res_o.value_kind   = kind;
      res_o.short_value  = short_val;
      if (kind == KIND_UUID128) begin
        res_o.uuid_high = cap_hi_d;
        res_o.uuid_low  = cap_lo_d;
      end
    end
  end

endmodule

// ===== sv/ble_adp_out_reg.sv =====
module ble_adp_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  ble_adp_pkg::result_t res_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ble_adp_pkg::result_t out_o
);
  import ble_adp_pkg::*;

  logic    vld_q;
  result_t data_q;

  // Free when empty or being emptied this cycle
  assign free_o      = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= load_i;
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= res_i;
    end
  end

endmodule

// ===== sv/ble_ad_structure_parser.sv =====
// Channel  Dir  tdata                                    tuser        tlast
// s_axis   in   ad_byte[7:0]                             -            last_byte
// m_axis   out  type,length,kind,short,uuid_hi,uuid_lo   field_valid  end_of_payload
//
// One payload byte is taken per cycle unless the input stage stalls; a byte
// passes the input register, then the result register, before its result is valid.
// The combinational parse step between the two registers sets the rate.
// rst_ni clears the parser to expect a length byte and empties both stages.
// A stalled result holds; the input stage stalls only on a byte that
// produces a result while the result register is still full.
module ble_ad_structure_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] ad_byte
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] field_type, [15:8] val_len, [18:16] value_kind,
  // [34:19] short_value, [98:35] uuid_high, [162:99] uuid_low, zero fill
  output logic [167:0] m_axis_tdata,
  output logic [0:0]   m_axis_tuser,  // [0] field_valid
  output logic         m_axis_tlast
);
  import ble_adp_pkg::*;

  result_t res;
  result_t out;
  logic    res_load;
  logic    res_free;

  ble_adp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .res_free_i (res_free),
    .res_load_o (res_load),
    .res_o      (res)
  );

  ble_adp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (res),
    .free_o      (res_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata = {5'd0, out.uuid_low, out.uuid_high, out.short_value,
                         out.value_kind, out.val_len, out.field_type};
  assign m_axis_tuser = out.field_valid;
  assign m_axis_tlast = out.end_of_payload;

endmodule

// ===== sv/ble_adp_checker.sv =====
module ble_adp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [167:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  import ble_adp_pkg::*;

  // No result shows while reset is applied
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A result without a structure only marks the payload end
  a_bare_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("empty result not an end mark");

  // A 128-bit uuid needs the matching type and a full capture
  a_uuid128: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[18:16] == KIND_UUID128 |->
      (m_axis_tdata[7:0] == TYPE_UUID128_PART || m_axis_tdata[7:0] == TYPE_UUID128_FULL)
      && m_axis_tdata[15:8] >= 8'(CAPTURE_BYTES))
    else $error("uuid128 result inconsistent");

  // Short value is zero for kinds that carry none
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[18:16] == KIND_NONE || m_axis_tdata[18:16] == KIND_NAME
      || m_axis_tdata[18:16] == KIND_UUID128) |-> m_axis_tdata[34:19] == 16'd0)
    else $error("short value set on wrong kind");

endmodule

bind ble_ad_structure_parser ble_adp_checker u_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ble_adp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;

  // Parser position within a payload
  typedef enum logic [1:0] {
    WAIT_LENGTH,
    WAIT_TYPE,
    TAKE_VALUE,
    SKIP_REST
  } ad_phase_e;

  // One directed byte; bare_end marks a byte whose result is a bare end marker
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bare_end;
  } stim_row_t;

  // Result with only end_of_payload set (it is the lowest bit)
  localparam result_t END_ONLY = result_t'(1);

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // [7:0] ad_byte
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [7:0] field_type, [15:8] val_len, [18:16] value_kind,
  // [34:19] short_value, [98:35] uuid_high, [162:99] uuid_low, zero fill
  logic [167:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;   // [0] field_valid
  logic         m_axis_tlast;

  // Parser state mirrored for prediction
  ad_phase_e    ad_phase;
  logic [7:0]   remaining;
  logic [7:0]   struct_type;
  logic [7:0]   struct_len;
  logic [63:0]  value_lo;
  logic [63:0]  value_hi;

  result_t      expected_fields [$];
  int unsigned  mismatches = 0;
  int unsigned  bytes_sent;
  int unsigned  cycles = 0;
  bit           tx_steady = 1'b0;
  bit           rx_steady = 1'b0;

  stim_row_t directed_rows [24] = '{
    '{8'h00, 1'b1, 1'b1},  // last byte on its own
    '{8'h02, 1'b0, 1'b0},  // flags, all bits set
    '{8'h01, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0},
    '{8'h02, 1'b0, 1'b0},  // tx power, most negative
    '{8'h0A, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0},
    '{8'h03, 1'b0, 1'b0},  // 16-bit uuid
    '{8'h03, 1'b0, 1'b0},
    '{8'h34, 1'b0, 1'b0},
    '{8'h12, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0},  // empty name closing the payload
    '{8'h08, 1'b1, 1'b0},
    '{8'h00, 1'b0, 1'b0},  // zero length: rest ignored
    '{8'h5A, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b1},
    '{8'h03, 1'b0, 1'b0},  // structure cut short by the payload end
    '{8'hFF, 1'b0, 1'b0},
    '{8'h11, 1'b1, 1'b1},
    '{8'hFF, 1'b1, 1'b1},  // length byte as the last byte
    '{8'h03, 1'b0, 1'b0},  // company id, ends with the payload
    '{8'hFF, 1'b0, 1'b0},
    '{8'h59, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0}
  };

  ble_ad_structure_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Advance the mirrored parser by one byte and give the result it causes
  task automatic parse_ad_byte(input logic [7:0] b, input logic last,
                               output bit emits, output result_t res);
    int         idx;
    bit         done;
    logic [7:0] vlen;
    done = 1'b0;
    res  = '0;
    case (ad_phase)
      WAIT_LENGTH: begin
        if (b == 8'h00) begin
          ad_phase = SKIP_REST;
        end else begin
          struct_len  = b;
          struct_type = 8'h00;
          value_lo    = '0;
          value_hi    = '0;
          ad_phase    = WAIT_TYPE;
        end
      end
      WAIT_TYPE: begin
        struct_type = b;
        remaining   = struct_len - 8'd1;
        if (remaining == 8'd0) begin
          done     = 1'b1;
          ad_phase = WAIT_LENGTH;
        end else begin
          ad_phase = TAKE_VALUE;
        end
      end
      TAKE_VALUE: begin
        // Keep the first value bytes only; the rest are just counted
        idx = struct_len - 8'd1 - remaining;
        if (idx < 8) value_lo[8*idx +: 8] = b;
        else if (idx < CAPTURE_BYTES) value_hi[8*(idx-8) +: 8] = b;
        remaining = remaining - 8'd1;
        if (remaining == 8'd0) begin
          done     = 1'b1;
          ad_phase = WAIT_LENGTH;
        end
      end
      default: ;
    endcase

    if (done) begin
      vlen             = struct_len - 8'd1;
      res.field_valid  = 1'b1;
      res.field_type   = struct_type;
      res.val_len      = vlen;
      if (struct_type == TYPE_FLAGS && vlen >= 1) begin
        res.value_kind  = KIND_FLAGS;
        res.short_value = {8'h00, value_lo[7:0]};
      end else if (struct_type == TYPE_TX_POWER && vlen >= 1) begin
        res.value_kind  = KIND_TX_POWER;
        res.short_value = {8'h00, value_lo[7:0]};
      end else if ((struct_type == TYPE_UUID16_PART || struct_type == TYPE_UUID16_FULL)
                   && vlen >= 2) begin
        res.value_kind  = KIND_UUID16;
        res.short_value = value_lo[15:0];
      end else if ((struct_type == TYPE_UUID128_PART || struct_type == TYPE_UUID128_FULL)
                   && vlen >= CAPTURE_BYTES) begin
        res.value_kind = KIND_UUID128;
        res.uuid_high  = value_hi;
        res.uuid_low   = value_lo;
      end else if (struct_type == TYPE_COMPANY_ID && vlen >= 2) begin
        res.value_kind  = KIND_COMPANY;
        res.short_value = value_lo[15:0];
      end else if (struct_type == TYPE_NAME_SHORT || struct_type == TYPE_NAME_FULL) begin
        res.value_kind = KIND_NAME;
      end
    end

    // Payload end: mark the result and start afresh
    if (last) begin
      res.end_of_payload = 1'b1;
      ad_phase    = WAIT_LENGTH;
      remaining   = 8'd0;
      struct_type = 8'd0;
      struct_len  = 8'd0;
      value_lo    = '0;
      value_hi    = '0;
    end
    emits = done || last;
  endtask

  // Offer one byte after a random gap, hold until the transfer, then predict
  task automatic send_ad_byte(input logic [7:0] b, input logic last, input bit bare_end);
    int      gap;
    bit      emits;
    result_t res;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_ad_byte(b, last, emits, res);
    if (bare_end) expected_fields = {expected_fields, END_ONLY};
    else if (emits) expected_fields = {expected_fields, res};
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Build one payload: mostly well-formed structures, some noise and bad endings
  task automatic send_random_payload();
    logic [7:0] pl [$];
    logic [7:0] ad_type;
    int         vlen;
    int         cut_len;
    int         ending;
    pl = {};
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 12)) pl = {pl, 8'($urandom)};
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 10))
          0: ad_type = TYPE_FLAGS;
          1: ad_type = TYPE_UUID16_PART;
          2: ad_type = TYPE_UUID16_FULL;
          3: ad_type = TYPE_UUID128_PART;
          4: ad_type = TYPE_UUID128_FULL;
          5: ad_type = TYPE_NAME_SHORT;
          6: ad_type = TYPE_NAME_FULL;
          7: ad_type = TYPE_TX_POWER;
          8: ad_type = TYPE_COMPANY_ID;
          default: ad_type = 8'($urandom);
        endcase
        if (ad_type == TYPE_UUID128_PART || ad_type == TYPE_UUID128_FULL) begin
          vlen = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 20) : CAPTURE_BYTES;
        end else if ($urandom_range(0, 29) == 0) begin
          // Long value: beyond the capture, up to the largest length
          vlen = $urandom_range(0, 1) ? 254 : $urandom_range(17, 253);
        end else begin
          vlen = $urandom_range(0, 5);
        end
        pl = {pl, 8'(vlen + 1)};
        pl = {pl, ad_type};
        repeat (vlen) pl = {pl, 8'($urandom)};
      end
      ending = $urandom_range(0, 9);
      if (ending == 0) begin
        // Structure interrupted by the payload end
        cut_len = $urandom_range(2, 20);
        pl = {pl, 8'(cut_len)};
        repeat ($urandom_range(0, cut_len - 1)) pl = {pl, 8'($urandom)};
      end else if (ending == 1) begin
        pl = {pl, 8'h00};
        repeat ($urandom_range(0, 6)) pl = {pl, 8'($urandom)};
      end
    end
    foreach (pl[i]) send_ad_byte(pl[i], i == pl.size() - 1, 1'b0);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, actual %0h", name, exp, act);
      mismatches++;
    end
  endtask

  // Result side: random stalls, compare each transfer with the oldest expectation
  initial begin
    int      gap;
    result_t exp;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (expected_fields.size() == 0) begin
        $error("result transfer with no expectation waiting");
        mismatches++;
      end else begin
        exp = expected_fields.pop_front();
        check_field("field_valid", 64'(exp.field_valid), 64'(m_axis_tuser[0]));
        check_field("field_type", 64'(exp.field_type), 64'(m_axis_tdata[7:0]));
        check_field("val_len", 64'(exp.val_len), 64'(m_axis_tdata[15:8]));
        check_field("value_kind", 64'(exp.value_kind), 64'(m_axis_tdata[18:16]));
        check_field("short_value", 64'(exp.short_value), 64'(m_axis_tdata[34:19]));
        check_field("uuid_high", exp.uuid_high, m_axis_tdata[98:35]);
        check_field("uuid_low", exp.uuid_low, m_axis_tdata[162:99]);
        check_field("end_of_payload", 64'(exp.end_of_payload), 64'(m_axis_tlast));
      end
      @(negedge clk_i);
    end
  end

  // Byte side: reset, directed table, random payloads, drain
  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    bytes_sent    = 0;
    ad_phase      = WAIT_LENGTH;
    remaining     = 8'd0;
    struct_type   = 8'd0;
    struct_len    = 8'd0;
    value_lo      = '0;
    value_hi      = '0;
    #1 rst_ni     = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_ad_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].bare_end);

    bytes_sent = 0;
    while (bytes_sent < RANDOM_ITEMS) send_random_payload();
    s_axis_tvalid <= 1'b0;

    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ble_adp_pkg.sv
sv/ble_adp_core.sv
sv/ble_adp_out_reg.sv
sv/ble_ad_structure_parser.sv
sv/ble_adp_checker.sv
tb/testbench.sv
